@@ rtl/core/utc_date_to_ptp_timestamp_defines.svh @@
// ----------------------------------------------------------------------------
// UTC date to PTP timestamp - assertion macros
// Shared property shorthands on clk and arst_n for the converter pipeline.
// ----------------------------------------------------------------------------
`ifndef UTC_DATE_TO_PTP_TIMESTAMP_DEFINES_SVH
`define UTC_DATE_TO_PTP_TIMESTAMP_DEFINES_SVH

// same-cycle implication
`define UTCPTP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UTCPTP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/utcptp_pkg.sv @@
// ----------------------------------------------------------------------------
// UTC date to PTP timestamp - package
// Request and result types, calendar constants and the month-day table.
// ----------------------------------------------------------------------------
package utcptp_pkg;

	typedef struct packed {
		logic        time_ok_flag;
		logic        date_ok_flag;
		logic [15:0] cal_year;
		logic [7:0]  cal_month;
		logic [7:0]  cal_day;
		logic [7:0]  utc_hour;
		logic [7:0]  utc_minute;
		logic [7:0]  utc_second;
		logic [6:0]  hundredths;
	} in_req_t;

	typedef struct packed {
		logic        conv_ok;
		logic [47:0] ptp_secs;
		logic [29:0] ptp_nsec;
	} out_res_t;

	localparam int ADDR_W = 3;
	localparam logic [0:0] REG_TAI_OFFSET = 1'b0;
	localparam logic [7:0] TAI_OFFSET_RESET = 8'd37;

	localparam logic [15:0] EPOCH_YEAR = 16'd1970;
	// leap years in 1..1969
	localparam logic [24:0] LEAPS_BEFORE_EPOCH = 25'd477;
	localparam logic [16:0] SECS_PER_DAY = 17'd86400;
	localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN = 17'd60;
	localparam logic [29:0] NSEC_PER_HUNDREDTH = 30'd10000000;
	localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

	// x/25 = (x * RECIP25) >> RECIP_SHIFT, exact for x below 2^14
	localparam logic [12:0] RECIP25 = 13'd5243;
	localparam int RECIP_SHIFT = 17;
	localparam logic [4:0] DIV25 = 5'd25;

	// days before the first of the given month, non-leap year
	function automatic logic [8:0] cum_days(input logic [3:0] month);
		logic [8:0] d;
		unique case (month)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

@@ rtl/core/utc_date_to_ptp_timestamp.sv @@
// ----------------------------------------------------------------------------
// UTC date to PTP timestamp
// Turns a UTC calendar reading into TAI seconds and nanoseconds since 1970.
// ----------------------------------------------------------------------------
// Accepts one request per clock while in_stall is low and returns exactly
// one result per request, in order. The four register stages are: range
// checks and the divide-by-25 reciprocal products, the day count, the
// day-to-seconds multiply, and the final sum with the TAI offset in the
// output register. Bubbles collapse, so a stall at the output only pushes
// back on the input once every stage is full. Rejected readings (flag
// clear, field out of range, or the epoch instant itself) give conv_ok
// low with zero seconds and nanoseconds. The TAI offset sits at byte
// address 0 of the APB port and resets to 37.
`include "utc_date_to_ptp_timestamp_defines.svh"

module utc_date_to_ptp_timestamp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  utcptp_pkg::in_req_t           in_req,
	output logic                          out_valid,
	input  logic                          out_stall,
	output utcptp_pkg::out_res_t          out_res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [utcptp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// configuration
	logic [7:0] tai_offset_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tai_offset_q <= utcptp_pkg::TAI_OFFSET_RESET;
		end else if (psel && penable && pwrite &&
		             paddr[2] == utcptp_pkg::REG_TAI_OFFSET) begin
			tai_offset_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == utcptp_pkg::REG_TAI_OFFSET) begin
			prdata = {24'd0, tai_offset_q};
		end
	end

	// flow control
	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4    = !out_valid || !out_stall;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				out_valid <= v_s3;
			end
		end
	end

	// stage 1: checks, month offset, time of day, nanoseconds, reciprocal products
	logic        ok_c1;
	logic [16:0] tod_c1;
	logic [8:0]  mday_c1;
	logic [15:0] yn_c1;

	logic        ok_s1;
	logic [15:0] year_s1;
	logic        mgt2_s1;
	logic [8:0]  mday_s1;
	logic [16:0] tod_s1;
	logic [29:0] nsec_s1;
	logic [26:0] pyn4_s1;
	logic [24:0] pyn16_s1;
	logic [26:0] py4_s1;
	logic [24:0] py16_s1;

	always_comb begin
		ok_c1 = in_req.time_ok_flag && in_req.date_ok_flag &&
		        in_req.cal_year >= utcptp_pkg::EPOCH_YEAR &&
		        in_req.cal_month >= 8'd1 && in_req.cal_month <= 8'd12 &&
		        in_req.cal_day >= 8'd1 && in_req.cal_day <= 8'd31 &&
		        in_req.utc_hour <= 8'd23 && in_req.utc_minute <= 8'd59 &&
		        in_req.utc_second <= 8'd59 && in_req.hundredths <= 7'd99;
		tod_c1 = 17'(17'(in_req.utc_hour[4:0]) * utcptp_pkg::SECS_PER_HOUR) +
		         17'(17'(in_req.utc_minute[5:0]) * utcptp_pkg::SECS_PER_MIN) +
		         17'(in_req.utc_second[5:0]);
		mday_c1 = utcptp_pkg::cum_days(in_req.cal_month[3:0]) +
		          9'(in_req.cal_day[4:0]) - 9'd1;
		yn_c1 = in_req.cal_year - 16'd1;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ok_s1    <= ok_c1;
			year_s1  <= in_req.cal_year;
			mgt2_s1  <= in_req.cal_month > 8'd2;
			mday_s1  <= mday_c1;
			tod_s1   <= tod_c1;
			nsec_s1  <= 30'(30'(in_req.hundredths) * utcptp_pkg::NSEC_PER_HUNDREDTH);
			pyn4_s1  <= 27'(yn_c1[15:2]) * 27'(utcptp_pkg::RECIP25);
			pyn16_s1 <= 25'(yn_c1[15:4]) * 25'(utcptp_pkg::RECIP25);
			py4_s1   <= 27'(in_req.cal_year[15:2]) * 27'(utcptp_pkg::RECIP25);
			py16_s1  <= 25'(in_req.cal_year[15:4]) * 25'(utcptp_pkg::RECIP25);
		end
	end

	// stage 2: days since the epoch
	logic [9:0]  q100_c2;
	logic [7:0]  q400_c2;
	logic [9:0]  qa_c2;
	logic [7:0]  qb_c2;
	logic [15:0] yn_c2;
	logic        leap_c2;
	logic [24:0] days_c2;

	logic        ok_s2;
	logic [24:0] days_s2;
	logic [16:0] tod_s2;
	logic [29:0] nsec_s2;

	always_comb begin
		yn_c2   = year_s1 - 16'd1;
		q100_c2 = pyn4_s1[utcptp_pkg::RECIP_SHIFT +: 10];
		q400_c2 = pyn16_s1[utcptp_pkg::RECIP_SHIFT +: 8];
		qa_c2   = py4_s1[utcptp_pkg::RECIP_SHIFT +: 10];
		qb_c2   = py16_s1[utcptp_pkg::RECIP_SHIFT +: 8];
		// divisible by 4, and not by 100 unless by 400
		leap_c2 = (year_s1[1:0] == 2'd0) &&
		          ((14'(year_s1[15:2]) != 14'(qa_c2) * 14'(utcptp_pkg::DIV25)) ||
		           ((year_s1[3:0] == 4'd0) &&
		            (12'(year_s1[15:4]) == 12'(qb_c2) * 12'(utcptp_pkg::DIV25))));
		days_c2 = 25'(25'(year_s1 - utcptp_pkg::EPOCH_YEAR) *
		              25'(utcptp_pkg::DAYS_PER_YEAR)) +
		          25'(yn_c2[15:2]) - 25'(q100_c2) + 25'(q400_c2) -
		          utcptp_pkg::LEAPS_BEFORE_EPOCH + 25'(mday_s1) +
		          25'(mgt2_s1 && leap_c2);
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ok_s2   <= ok_s1;
			days_s2 <= days_c2;
			tod_s2  <= tod_s1;
			nsec_s2 <= nsec_s1;
		end
	end

	// stage 3: days to seconds; the epoch instant itself is rejected
	logic        ok_s3;
	logic [41:0] dsec_s3;
	logic [16:0] tod_s3;
	logic [29:0] nsec_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			ok_s3   <= ok_s2 && !(days_s2 == 25'd0 && tod_s2 == 17'd0);
			dsec_s3 <= 42'(days_s2) * 42'(utcptp_pkg::SECS_PER_DAY);
			tod_s3  <= tod_s2;
			nsec_s3 <= nsec_s2;
		end
	end

	// stage 4: TAI seconds into the output register
	logic [47:0] secs_c4;

	assign secs_c4 = 48'(dsec_s3) + 48'(tod_s3) + 48'(tai_offset_q);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			out_res.conv_ok  <= ok_s3;
			out_res.ptp_secs <= ok_s3 ? secs_c4 : 48'd0;
			out_res.ptp_nsec <= ok_s3 ? nsec_s3 : 30'd0;
		end
	end

	`UTCPTP_ASSERT_IMP(a_reject_zero, out_valid && !out_res.conv_ok, out_res.ptp_secs == 48'd0 && out_res.ptp_nsec == 30'd0, "rejected result carries a non-zero timestamp")
	`UTCPTP_ASSERT_IMP(a_accept_nonzero, out_valid && out_res.conv_ok, out_res.ptp_secs != 48'd0 && out_res.ptp_nsec <= 30'd990000000, "accepted result out of range")
	`UTCPTP_ASSERT_IMP(a_full_backpressure, v_s1 && v_s2 && v_s3 && out_valid && out_stall, in_stall, "full pipeline took a request under stall")
	`UTCPTP_ASSERT_NXT(a_stage_advance, v_s3 && en_s4, out_valid, "result lost between last stage and output")

endmodule
